// ----- hw/rtl/csp_pkg.sv -----
// Shared types and constants of the call stack profiler.
// Used by csp_ftab, csp_dpath, csp_ctrl and call_stack_profiler; depends on nothing.
package csp_pkg;

  localparam int TIME_W   = 64;
  localparam int COUNT_W  = 32;
  localparam int NEST_W   = 7;
  localparam int LEVEL_W  = 7;
  localparam int FID_W    = 8;
  localparam int OVH_W    = 16;
  localparam int CFG_IDX_W = 8;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERHEAD = 8'd1;

  // Result tdata layout
  localparam int OUT_TDATA_W = 184;
  localparam int OUT_INC_BIT = 182;

  typedef enum logic [1:0] {
    CMD_ENTER = 2'd0,
    CMD_EXIT  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_IGNORED  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  // Which function record a table read addresses
  typedef enum logic [1:0] {
    SEL_FID  = 2'd0,
    SEL_TOP  = 2'd1,
    SEL_ZERO = 2'd2
  } fn_sel_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_TOP,
    S_DIFF_S,
    S_CHG_S,
    S_T_WR,
    S_RD_FN,
    S_FN_UPD,
    S_ACCS,
    S_DIFF_O,
    S_CHG_O,
    S_X_WR,
    S_X_NT
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0]  self_time;
    logic [TIME_W-1:0]  incl_time;
    logic [TIME_W-1:0]  start;
    logic [TIME_W-1:0]  outer;
    logic [COUNT_W-1:0] count;
    logic [NEST_W-1:0]  nest;
  } rec_t;

  typedef struct packed {
    logic self_time;
    logic incl_time;
    logic start;
    logic outer;
    logic count;
    logic nest;
  } rec_we_t;

  // Controller to datapath
  typedef struct packed {
    logic    accept;
    logic    clr_wr;
    logic    rd_issue;
    fn_sel_e rd_sel;
    logic    diff;
    logic    diff_outer;
    logic    chg;
    logic    accs;
    logic    top_wr;
    logic    fn_push;
    logic    fn_ovf;
    logic    fn_emit;
    status_e emit_status;
    logic    x_wr;
    logic    x_nt;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic enable;
    logic sp_zero;
    logic sp_full;
    logic sp_ge2;
    logic out_free;
    logic clr_last;
  } dp_stat_t;

endpackage

// ----- hw/rtl/csp_ftab.sv -----
// Per-function record tables: one memory per field, shared read and write address.
// Depends on csp_pkg for the record and write-enable types.
module csp_ftab #(
  parameter int FUNC_COUNT = 256
) (
  input  logic                          clk_i,
  input  logic                          re_i,
  input  logic [$clog2(FUNC_COUNT)-1:0] raddr_i,
  output csp_pkg::rec_t                 rdata_o,
  input  csp_pkg::rec_we_t              we_i,
  input  logic [$clog2(FUNC_COUNT)-1:0] waddr_i,
  input  csp_pkg::rec_t                 wdata_i
);

  logic [csp_pkg::TIME_W-1:0]  self_mem  [FUNC_COUNT];
  logic [csp_pkg::TIME_W-1:0]  incl_mem  [FUNC_COUNT];
  logic [csp_pkg::TIME_W-1:0]  start_mem [FUNC_COUNT];
  logic [csp_pkg::TIME_W-1:0]  outer_mem [FUNC_COUNT];
  logic [csp_pkg::COUNT_W-1:0] count_mem [FUNC_COUNT];
  logic [csp_pkg::NEST_W-1:0]  nest_mem  [FUNC_COUNT];

  always_ff @(posedge clk_i) begin
    if (we_i.self_time) self_mem[waddr_i]  <= wdata_i.self_time;
    if (we_i.incl_time) incl_mem[waddr_i]  <= wdata_i.incl_time;
    if (we_i.start)     start_mem[waddr_i] <= wdata_i.start;
    if (we_i.outer)     outer_mem[waddr_i] <= wdata_i.outer;
    if (we_i.count)     count_mem[waddr_i] <= wdata_i.count;
    if (we_i.nest)      nest_mem[waddr_i]  <= wdata_i.nest;
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o.self_time <= self_mem[raddr_i];
      rdata_o.incl_time <= incl_mem[raddr_i];
      rdata_o.start     <= start_mem[raddr_i];
      rdata_o.outer     <= outer_mem[raddr_i];
      rdata_o.count     <= count_mem[raddr_i];
      rdata_o.nest      <= nest_mem[raddr_i];
    end
  end

endmodule

// ----- hw/rtl/csp_dpath.sv -----
// Datapath: input capture, call stack memory, interval unit, record updates,
// configuration registers and result register. Uses csp_pkg and csp_ftab.
module csp_dpath #(
  parameter int FUNC_COUNT  = 256,
  parameter int STACK_DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  csp_pkg::ctl_cmd_t                   cmd_i,
  output csp_pkg::dp_stat_t                   stat_o,
  input  logic [csp_pkg::FID_W-1:0]           in_fid_i,
  input  logic [csp_pkg::TIME_W-1:0]          in_time_i,
  input  logic                                cfg_valid_i,
  input  logic [csp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [csp_pkg::OVH_W-1:0]           cfg_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          out_status_o,
  output logic [csp_pkg::OUT_TDATA_W-1:0]     out_data_o
);

  localparam int FIDX_W  = $clog2(FUNC_COUNT);
  localparam int SP_W    = $clog2(STACK_DEPTH + 1);
  localparam int SADDR_W = $clog2(STACK_DEPTH);
  localparam int FMAP_N  = 2 ** csp_pkg::FID_W;

  // function_id modulo FUNC_COUNT as a constant table, built with a wrapping counter
  function automatic logic [FMAP_N*FIDX_W-1:0] build_fmap();
    logic [FMAP_N*FIDX_W-1:0] res;
    logic [FIDX_W-1:0]        r;
    res = '0;
    r   = '0;
    for (int i = 0; i < FMAP_N; i++) begin
      res[i*FIDX_W +: FIDX_W] = r;
      if (int'(r) == FUNC_COUNT - 1) r = '0;
      else r = r + 1'b1;
    end
    return res;
  endfunction

  localparam logic [FMAP_N*FIDX_W-1:0] FMAP = build_fmap();

  logic [FIDX_W-1:0]          idx_q, top_q, rec_q, clr_q, stk_rd_q;
  logic [csp_pkg::TIME_W-1:0] now_q, diff_q, chg_q, selfn_q;
  logic [csp_pkg::TIME_W-1:0] novh_q, novh1_q;
  logic [SP_W-1:0]            sp_q;
  logic                       lost_q, enable_q, out_valid_q;
  logic [FIDX_W-1:0]          stk_mem [STACK_DEPTH];

  csp_pkg::rec_t    rd;
  csp_pkg::rec_t    wdata;
  csp_pkg::rec_we_t we;
  logic [FIDX_W-1:0] raddr, waddr;
  logic [csp_pkg::TIME_W-1:0] stamp, incl_new;
  logic [csp_pkg::NEST_W-1:0] nest_dec;
  logic [csp_pkg::TIME_W-1:0] ovh_ext;

  assign ovh_ext  = {{(csp_pkg::TIME_W-csp_pkg::OVH_W){1'b0}}, cfg_data_i};
  assign nest_dec = rd.nest - 1'b1;
  assign incl_new = (nest_dec == '0) ? rd.incl_time + chg_q : rd.incl_time;
  assign stamp    = cmd_i.diff_outer ? rd.outer : rd.start;

  always_comb begin
    unique case (cmd_i.rd_sel)
      csp_pkg::SEL_FID: raddr = idx_q;
      csp_pkg::SEL_TOP: raddr = top_q;
      default:          raddr = '0;
    endcase
  end

  // Table write port
  always_comb begin
    we    = '0;
    waddr = rec_q;
    wdata = '0;
    priority if (cmd_i.clr_wr) begin
      we    = '1;
      waddr = clr_q;
    end else if (cmd_i.top_wr) begin
      we.self_time    = 1'b1;
      waddr           = top_q;
      wdata.self_time = rd.self_time + chg_q;
    end else if (cmd_i.fn_push) begin
      we.count    = 1'b1;
      we.start    = 1'b1;
      we.nest     = 1'b1;
      we.outer    = (rd.nest == '0);
      wdata.count = rd.count + 1'b1;
      wdata.start = now_q;
      wdata.outer = now_q;
      wdata.nest  = rd.nest + 1'b1;
    end else if (cmd_i.x_wr) begin
      we.self_time    = 1'b1;
      we.incl_time    = 1'b1;
      we.nest         = 1'b1;
      wdata.self_time = selfn_q;
      wdata.incl_time = incl_new;
      wdata.nest      = nest_dec;
    end else if (cmd_i.x_nt) begin
      we.start    = 1'b1;
      waddr       = stk_rd_q;
      wdata.start = now_q;
    end else begin
      we = '0;
    end
  end

  csp_ftab #(
    .FUNC_COUNT(FUNC_COUNT)
  ) u_ftab (
    .clk_i  (clk_i),
    .re_i   (cmd_i.rd_issue),
    .raddr_i(raddr),
    .rdata_o(rd),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata)
  );

  // Call stack: the entry below the top is read every cycle for the restart after a pop
  always_ff @(posedge clk_i) begin
    if (cmd_i.fn_push) stk_mem[sp_q[SADDR_W-1:0]] <= idx_q;
    stk_rd_q <= stk_mem[sp_q[SADDR_W-1:0] - SADDR_W'(2)];
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      idx_q <= FMAP[int'(in_fid_i)*FIDX_W +: FIDX_W];
      now_q <= in_time_i;
    end
    if (cmd_i.rd_issue) rec_q <= raddr;
    if (cmd_i.diff) diff_q <= now_q - stamp;
    // |d| - overhead in one add: -d - ovh equals ~d + (1 - ovh)
    if (cmd_i.chg) chg_q <= (diff_q[csp_pkg::TIME_W-1] ? ~diff_q : diff_q)
                          + (diff_q[csp_pkg::TIME_W-1] ? novh1_q : novh_q);
    if (cmd_i.accs) selfn_q <= rd.self_time + chg_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q     <= '0;
      top_q    <= '0;
      lost_q   <= 1'b0;
      clr_q    <= '0;
      enable_q <= 1'b1;
      novh_q   <= '0;
      novh1_q  <= csp_pkg::TIME_W'(1);
    end else begin
      if (cmd_i.clr_wr) clr_q <= clr_q + 1'b1;
      if (cmd_i.fn_push) begin
        sp_q  <= sp_q + 1'b1;
        top_q <= idx_q;
      end
      if (cmd_i.x_wr) sp_q <= sp_q - 1'b1;
      if (cmd_i.x_nt) top_q <= stk_rd_q;
      if (cmd_i.fn_ovf) lost_q <= 1'b1;
      if (cfg_valid_i) begin
        if (cfg_index_i == csp_pkg::CFG_ENABLE) enable_q <= cfg_data_i[0];
        if (cfg_index_i == csp_pkg::CFG_OVERHEAD) begin
          novh_q  <= '0 - ovh_ext;
          novh1_q <= csp_pkg::TIME_W'(1) - ovh_ext;
        end
      end
    end
  end

  // Result register
  logic emit;
  assign emit = cmd_i.fn_push || cmd_i.fn_ovf || cmd_i.fn_emit || cmd_i.x_wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  logic [csp_pkg::TIME_W-1:0]  o_self, o_incl;
  logic [csp_pkg::COUNT_W-1:0] o_count;
  logic [csp_pkg::NEST_W-1:0]  o_nest;
  logic [SP_W-1:0]             o_sp;
  logic                        o_lost;
  csp_pkg::status_e            o_status;

  always_comb begin
    o_self   = rd.self_time;
    o_incl   = rd.incl_time;
    o_count  = rd.count;
    o_nest   = rd.nest;
    o_sp     = sp_q;
    o_lost   = lost_q;
    o_status = cmd_i.emit_status;
    priority if (cmd_i.fn_push) begin
      o_count  = rd.count + 1'b1;
      o_nest   = rd.nest + 1'b1;
      o_sp     = sp_q + 1'b1;
      o_status = csp_pkg::ST_DONE;
    end else if (cmd_i.fn_ovf) begin
      o_lost   = 1'b1;
      o_status = csp_pkg::ST_OVERFLOW;
    end else if (cmd_i.x_wr) begin
      o_self   = selfn_q;
      o_incl   = incl_new;
      o_nest   = nest_dec;
      o_sp     = sp_q - 1'b1;
      o_status = csp_pkg::ST_DONE;
    end else begin
      o_status = cmd_i.emit_status;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_status_o <= o_status;
      out_data_o   <= {1'b0, o_lost, csp_pkg::LEVEL_W'(o_sp), o_nest, o_count,
                       o_incl, o_self, csp_pkg::FID_W'(rec_q)};
    end
  end

  assign out_valid_o = out_valid_q;

  assign stat_o.enable   = enable_q;
  assign stat_o.sp_zero  = (sp_q == '0);
  assign stat_o.sp_full  = (sp_q == SP_W'(STACK_DEPTH));
  assign stat_o.sp_ge2   = (sp_q >= SP_W'(2));
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign stat_o.clr_last = (clr_q == FIDX_W'(FUNC_COUNT - 1));

endmodule

// ----- hw/rtl/csp_ctrl.sv -----
// Controller: sequences the clearing pass and each event through the datapath.
// Uses csp_pkg for states, codes and the command/status structs.
module csp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_cmd_i,
  output logic              in_ready_o,
  input  csp_pkg::dp_stat_t stat_i,
  output csp_pkg::ctl_cmd_t cmd_o
);

  csp_pkg::state_e  state_q, state_d;
  csp_pkg::fn_sel_e sel_q, sel_d;
  csp_pkg::status_e est_q, est_d;
  logic             exit_q, exit_d;
  logic             plain_q, plain_d;
  logic             ovf_q, ovf_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csp_pkg::S_CLEAR;
      sel_q   <= csp_pkg::SEL_FID;
      est_q   <= csp_pkg::ST_DONE;
      exit_q  <= 1'b0;
      plain_q <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      est_q   <= est_d;
      exit_q  <= exit_d;
      plain_q <= plain_d;
      ovf_q   <= ovf_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    est_d       = est_q;
    exit_d      = exit_q;
    plain_d     = plain_q;
    ovf_d       = ovf_q;
    cmd_o       = '0;
    cmd_o.rd_sel = sel_q;
    cmd_o.emit_status = est_q;
    in_ready_o  = 1'b0;
    unique case (state_q)
      csp_pkg::S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) state_d = csp_pkg::S_IDLE;
      end
      csp_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          exit_d  = 1'b0;
          plain_d = 1'b1;
          ovf_d   = 1'b0;
          sel_d   = csp_pkg::SEL_FID;
          est_d   = csp_pkg::ST_IGNORED;
          state_d = csp_pkg::S_RD_FN;
          unique case (csp_pkg::cmd_e'(in_cmd_i))
            csp_pkg::CMD_ENTER: begin
              if (stat_i.enable) begin
                plain_d = 1'b0;
                ovf_d   = stat_i.sp_full;
                state_d = stat_i.sp_zero ? csp_pkg::S_RD_FN : csp_pkg::S_RD_TOP;
              end
            end
            csp_pkg::CMD_EXIT: begin
              if (stat_i.sp_zero) begin
                sel_d = csp_pkg::SEL_ZERO;
              end else if (!stat_i.enable) begin
                sel_d = csp_pkg::SEL_TOP;
              end else begin
                exit_d  = 1'b1;
                plain_d = 1'b0;
                state_d = csp_pkg::S_RD_TOP;
              end
            end
            csp_pkg::CMD_QUERY: est_d = csp_pkg::ST_DONE;
            default: est_d = csp_pkg::ST_IGNORED;
          endcase
        end
      end
      csp_pkg::S_RD_TOP: begin
        cmd_o.rd_issue = 1'b1;
        cmd_o.rd_sel   = csp_pkg::SEL_TOP;
        state_d        = csp_pkg::S_DIFF_S;
      end
      csp_pkg::S_DIFF_S: begin
        cmd_o.diff = 1'b1;
        state_d    = csp_pkg::S_CHG_S;
      end
      csp_pkg::S_CHG_S: begin
        cmd_o.chg = 1'b1;
        state_d   = exit_q ? csp_pkg::S_ACCS : csp_pkg::S_T_WR;
      end
      csp_pkg::S_T_WR: begin
        cmd_o.top_wr = 1'b1;
        state_d      = csp_pkg::S_RD_FN;
      end
      csp_pkg::S_RD_FN: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = csp_pkg::S_FN_UPD;
      end
      csp_pkg::S_FN_UPD: begin
        // hold until the result register can take the record
        if (stat_i.out_free) begin
          priority if (plain_q) cmd_o.fn_emit = 1'b1;
          else if (ovf_q) cmd_o.fn_ovf = 1'b1;
          else cmd_o.fn_push = 1'b1;
          state_d = csp_pkg::S_IDLE;
        end
      end
      csp_pkg::S_ACCS: begin
        cmd_o.accs = 1'b1;
        state_d    = csp_pkg::S_DIFF_O;
      end
      csp_pkg::S_DIFF_O: begin
        cmd_o.diff       = 1'b1;
        cmd_o.diff_outer = 1'b1;
        state_d          = csp_pkg::S_CHG_O;
      end
      csp_pkg::S_CHG_O: begin
        cmd_o.chg = 1'b1;
        state_d   = csp_pkg::S_X_WR;
      end
      csp_pkg::S_X_WR: begin
        if (stat_i.out_free) begin
          cmd_o.x_wr = 1'b1;
          state_d    = stat_i.sp_ge2 ? csp_pkg::S_X_NT : csp_pkg::S_IDLE;
        end
      end
      csp_pkg::S_X_NT: begin
        cmd_o.x_nt = 1'b1;
        state_d    = csp_pkg::S_IDLE;
      end
      default: state_d = csp_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/call_stack_profiler.sv -----
// Top level of the call stack profiler: stream ports, configuration port,
// controller and datapath. Uses csp_pkg, csp_ctrl and csp_dpath.
//
//  channel  direction  handshake              payload
//  s_axis   in         s_axis_tvalid/tready   tuser command, tdata function_id, timestamp
//  m_axis   out        m_axis_tvalid/tready   tuser status, tdata record fields
//  cfg      in         cfg_valid_i/ready_o    cfg_index_i, cfg_data_i
//
// One item is handled at a time: ready returns once the last has finished. The
// work per item is set by the registered reads of the record tables and the
// interval unit (difference, then abs less overhead), run for self time on an enter
// with a caller on the stack and on exit, and once more for inclusive time on exit;
// when a caller remains after an exit, its stamp restarts.
// After reset a clearing pass zeroes each entry of the record tables in turn; no
// item is accepted meanwhile, configuration writes are always taken.
// A stalled result waits in the output register; the event in flight holds at its
// write step until the register is free.
module call_stack_profiler #(
  parameter int FUNC_COUNT  = 256,
  parameter int STACK_DEPTH = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [71:0]                         s_axis_tdata,  // function_id, timestamp
  input  logic [1:0]                          s_axis_tuser,  // command
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // record_id, self_time, inclusive_time, call_count, nest_level, stack_level,
  // incomplete, zero pad
  output logic [csp_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic [1:0]                          m_axis_tuser,  // status
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [csp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [csp_pkg::OVH_W-1:0]           cfg_data_i
);

  csp_pkg::ctl_cmd_t cmd;
  csp_pkg::dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  csp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_cmd_i  (s_axis_tuser),
    .in_ready_o(s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  csp_dpath #(
    .FUNC_COUNT (FUNC_COUNT),
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_fid_i    (s_axis_tdata[7:0]),
    .in_time_i   (s_axis_tdata[71:8]),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_status_o(m_axis_tuser),
    .out_data_o  (m_axis_tdata)
  );

  // An overflow result always carries the sticky flag
  a_ovf_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == csp_pkg::ST_OVERFLOW)
      |-> m_axis_tdata[csp_pkg::OUT_INC_BIT])
    else $error("overflow result without incomplete flag");

  a_clear_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_wr |-> !s_axis_tready)
    else $error("input ready during clearing pass");

  a_restart_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.x_nt |-> $past(cmd.x_wr))
    else $error("caller restart without preceding pop");

  a_emit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.fn_push || cmd.fn_ovf || cmd.fn_emit || cmd.x_wr) |-> stat.out_free)
    else $error("result emitted into a full output register");

endmodule
